@@ src/ptc_pkg.sv @@
// ptc_pkg: shared widths, payload structs and sign helpers for the
// point-in-triangle classifier. No dependencies.
`default_nettype none

package ptc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int AREA_TOL_W  = 34;
    localparam int COORD_TOL_W = 16;
    localparam int AREA_CMP_W  = (CROSS_W > AREA_TOL_W) ? CROSS_W : AREA_TOL_W;
    localparam int COORD_CMP_W = (DIFF_W > COORD_TOL_W) ? DIFF_W : COORD_TOL_W;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;

    // register index, taken from the 8-byte slot of the address
    localparam logic REG_AREA_TOL  = 1'b0;
    localparam logic REG_COORD_TOL = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic [AREA_TOL_W-1:0]        area_tol_t;
    typedef logic [COORD_TOL_W-1:0]       coord_tol_t;

    typedef enum logic [1:0] {
        LOC_OUTSIDE = 2'd0,
        LOC_EDGE    = 2'd1,
        LOC_INSIDE  = 2'd2
    } loc_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } vec_t;

    // edge vectors and query offsets to each vertex
    typedef struct packed {
        vec_t bc;
        vec_t ca;
        vec_t ab;
        vec_t qa;
        vec_t qb;
        vec_t qc;
    } diff_set_t;

    typedef struct packed {
        prod_t l;
        prod_t r;
    } prod_pair_t;

    typedef struct packed {
        prod_pair_t bc_o;
        prod_pair_t bc_q;
        prod_pair_t ca_o;
        prod_pair_t ca_q;
        prod_pair_t ab_o;
        prod_pair_t ab_q;
        vec_t       qa;
        vec_t       qb;
        vec_t       qc;
    } prod_set_t;

    typedef struct packed {
        cross_t bc_o;
        cross_t bc_q;
        cross_t ca_o;
        cross_t ca_q;
        cross_t ab_o;
        cross_t ab_q;
        vec_t   qa;
        vec_t   qb;
        vec_t   qc;
    } cross_set_t;

    typedef struct packed {
        logic nz;
        logic neg;
    } sgn_t;

    typedef struct packed {
        logic zero;
        logic opp;
        logic seg;
    } edge_cls_t;

    function automatic sgn_t cross_sign(cross_t w, area_tol_t tol);
        logic [CROSS_W-1:0] mag;
        sgn_t               s;
        mag   = w[CROSS_W-1] ? $unsigned(-w) : $unsigned(w);
        s.neg = w[CROSS_W-1];
        s.nz  = AREA_CMP_W'(mag) > AREA_CMP_W'(tol);
        return s;
    endfunction

    function automatic sgn_t diff_sign(diff_t d, coord_tol_t tol);
        logic [DIFF_W-1:0] mag;
        sgn_t              s;
        mag   = d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
        s.neg = d[DIFF_W-1];
        s.nz  = COORD_CMP_W'(mag) > COORD_CMP_W'(tol);
        return s;
    endfunction

    // side test of one edge plus segment membership of the query point
    function automatic edge_cls_t edge_class(cross_t c_opp, cross_t c_q, vec_t d1, vec_t d2,
                                             area_tol_t atol, coord_tol_t ctol);
        sgn_t      so;
        sgn_t      st;
        sgn_t      sx1;
        sgn_t      sx2;
        sgn_t      sy1;
        sgn_t      sy2;
        edge_cls_t r;
        so  = cross_sign(c_opp, atol);
        st  = cross_sign(c_q, atol);
        sx1 = diff_sign(d1.x, ctol);
        sx2 = diff_sign(d2.x, ctol);
        sy1 = diff_sign(d1.y, ctol);
        sy2 = diff_sign(d2.y, ctol);
        r.zero = !so.nz || !st.nz;
        r.opp  = so.neg != st.neg;
        if (st.nz)
            r.seg = 1'b0;
        else if (sx1.nz && sx2.nz)
            r.seg = sx1.neg != sx2.neg;
        else if (sy1.nz && sy2.nz)
            r.seg = sy1.neg != sy2.neg;
        else
            r.seg = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/ptc_regs.sv @@
// ptc_regs: APB-style register file holding the area and coordinate
// tolerances. Depends on ptc_pkg.
`default_nettype none

module ptc_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ptc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ptc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output ptc_pkg::area_tol_t                  area_tol,
    output ptc_pkg::coord_tol_t                 coord_tol
);

    ptc_pkg::area_tol_t  area_tol_reg;
    ptc_pkg::area_tol_t  area_tol_next;
    ptc_pkg::coord_tol_t coord_tol_reg;
    ptc_pkg::coord_tol_t coord_tol_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        area_tol_next  = area_tol_reg;
        coord_tol_next = coord_tol_reg;
        if (wr_en)
        begin
            unique case (paddr[3])
                ptc_pkg::REG_AREA_TOL:
                    area_tol_next = pwdata[ptc_pkg::AREA_TOL_W-1:0];
                ptc_pkg::REG_COORD_TOL:
                    coord_tol_next = pwdata[ptc_pkg::COORD_TOL_W-1:0];
                default:
                    area_tol_next = area_tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_tol_reg  <= '0;
            coord_tol_reg <= '0;
        end
        else
        begin
            area_tol_reg  <= area_tol_next;
            coord_tol_reg <= coord_tol_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            ptc_pkg::REG_AREA_TOL:
                prdata = ptc_pkg::APB_DATA_W'(area_tol_reg);
            ptc_pkg::REG_COORD_TOL:
                prdata = ptc_pkg::APB_DATA_W'(coord_tol_reg);
            default:
                prdata = '0;
        endcase
    end

    assign area_tol  = area_tol_reg;
    assign coord_tol = coord_tol_reg;

endmodule

`default_nettype wire

@@ src/ptc_diff.sv @@
// ptc_diff: first pipeline stage, edge vectors and query offsets.
// Depends on ptc_pkg.
`default_nettype none

module ptc_diff (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   up_hold,
    input  wire ptc_pkg::coord_t   qx,
    input  wire ptc_pkg::coord_t   qy,
    input  wire ptc_pkg::coord_t   ax,
    input  wire ptc_pkg::coord_t   ay,
    input  wire ptc_pkg::coord_t   bx,
    input  wire ptc_pkg::coord_t   by,
    input  wire ptc_pkg::coord_t   cx,
    input  wire ptc_pkg::coord_t   cy,
    output logic                   out_valid,
    input  wire logic              down_hold,
    output ptc_pkg::diff_set_t     out_data
);

    logic               valid_reg;
    logic               valid_next;
    ptc_pkg::diff_set_t data_reg;
    ptc_pkg::diff_set_t data_next;
    ptc_pkg::diff_set_t calc;
    logic               load;

    assign load    = !(valid_reg && down_hold);
    assign up_hold = !load;

    always_comb
    begin
        calc.bc.x = ptc_pkg::diff_t'(bx) - ptc_pkg::diff_t'(cx);
        calc.bc.y = ptc_pkg::diff_t'(by) - ptc_pkg::diff_t'(cy);
        calc.ca.x = ptc_pkg::diff_t'(cx) - ptc_pkg::diff_t'(ax);
        calc.ca.y = ptc_pkg::diff_t'(cy) - ptc_pkg::diff_t'(ay);
        calc.ab.x = ptc_pkg::diff_t'(ax) - ptc_pkg::diff_t'(bx);
        calc.ab.y = ptc_pkg::diff_t'(ay) - ptc_pkg::diff_t'(by);
        calc.qa.x = ptc_pkg::diff_t'(qx) - ptc_pkg::diff_t'(ax);
        calc.qa.y = ptc_pkg::diff_t'(qy) - ptc_pkg::diff_t'(ay);
        calc.qb.x = ptc_pkg::diff_t'(qx) - ptc_pkg::diff_t'(bx);
        calc.qb.y = ptc_pkg::diff_t'(qy) - ptc_pkg::diff_t'(by);
        calc.qc.x = ptc_pkg::diff_t'(qx) - ptc_pkg::diff_t'(cx);
        calc.qc.y = ptc_pkg::diff_t'(qy) - ptc_pkg::diff_t'(cy);
    end

    assign valid_next = load ? in_valid : valid_reg;
    assign data_next  = load ? calc : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ src/ptc_cross.sv @@
// ptc_cross: product stage and cross product stage for the six side tests.
// Depends on ptc_pkg.
`default_nettype none

module ptc_cross (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     up_hold,
    input  wire ptc_pkg::diff_set_t  in_data,
    output logic                     out_valid,
    input  wire logic                down_hold,
    output ptc_pkg::cross_set_t      out_data
);

    logic                p_valid_reg;
    logic                p_valid_next;
    ptc_pkg::prod_set_t  p_data_reg;
    ptc_pkg::prod_set_t  p_data_next;
    ptc_pkg::prod_set_t  p_calc;
    logic                p_load;
    logic                c_valid_reg;
    logic                c_valid_next;
    ptc_pkg::cross_set_t c_data_reg;
    ptc_pkg::cross_set_t c_data_next;
    ptc_pkg::cross_set_t c_calc;
    logic                c_load;

    // e.x * v.y and v.x * e.y for edge vector e and offset v
    function automatic ptc_pkg::prod_pair_t prods(ptc_pkg::vec_t e, ptc_pkg::vec_t v);
        ptc_pkg::prod_pair_t p;
        p.l = ptc_pkg::prod_t'(e.x) * ptc_pkg::prod_t'(v.y);
        p.r = ptc_pkg::prod_t'(v.x) * ptc_pkg::prod_t'(e.y);
        return p;
    endfunction

    function automatic ptc_pkg::cross_t diff_of(ptc_pkg::prod_pair_t p);
        return ptc_pkg::cross_t'(p.l) - ptc_pkg::cross_t'(p.r);
    endfunction

    assign c_load  = !(c_valid_reg && down_hold);
    assign p_load  = !(p_valid_reg && !c_load);
    assign up_hold = !p_load;

    always_comb
    begin
        p_calc.bc_o = prods(in_data.bc, in_data.ab);
        p_calc.bc_q = prods(in_data.bc, in_data.qb);
        p_calc.ca_o = prods(in_data.ca, in_data.bc);
        p_calc.ca_q = prods(in_data.ca, in_data.qc);
        p_calc.ab_o = prods(in_data.ab, in_data.ca);
        p_calc.ab_q = prods(in_data.ab, in_data.qa);
        p_calc.qa   = in_data.qa;
        p_calc.qb   = in_data.qb;
        p_calc.qc   = in_data.qc;
    end

    always_comb
    begin
        c_calc.bc_o = diff_of(p_data_reg.bc_o);
        c_calc.bc_q = diff_of(p_data_reg.bc_q);
        c_calc.ca_o = diff_of(p_data_reg.ca_o);
        c_calc.ca_q = diff_of(p_data_reg.ca_q);
        c_calc.ab_o = diff_of(p_data_reg.ab_o);
        c_calc.ab_q = diff_of(p_data_reg.ab_q);
        c_calc.qa   = p_data_reg.qa;
        c_calc.qb   = p_data_reg.qb;
        c_calc.qc   = p_data_reg.qc;
    end

    assign p_valid_next = p_load ? in_valid : p_valid_reg;
    assign p_data_next  = p_load ? p_calc : p_data_reg;
    assign c_valid_next = c_load ? p_valid_reg : c_valid_reg;
    assign c_data_next  = c_load ? c_calc : c_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_data_reg <= p_data_next;
        c_data_reg <= c_data_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

`default_nettype wire

@@ src/ptc_classify.sv @@
// ptc_classify: tolerance compare stage and final decision stage, which is
// also the output register. Depends on ptc_pkg.
`default_nettype none

module ptc_classify (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      up_hold,
    input  wire ptc_pkg::cross_set_t  in_data,
    input  wire ptc_pkg::area_tol_t   area_tol,
    input  wire ptc_pkg::coord_tol_t  coord_tol,
    output logic                      out_valid,
    input  wire logic                 down_hold,
    output ptc_pkg::loc_t             loc
);

    logic               e_valid_reg;
    logic               e_valid_next;
    ptc_pkg::edge_cls_t bc_reg;
    ptc_pkg::edge_cls_t bc_next;
    ptc_pkg::edge_cls_t ca_reg;
    ptc_pkg::edge_cls_t ca_next;
    ptc_pkg::edge_cls_t ab_reg;
    ptc_pkg::edge_cls_t ab_next;
    logic               e_load;
    logic               o_valid_reg;
    logic               o_valid_next;
    ptc_pkg::loc_t      loc_reg;
    ptc_pkg::loc_t      loc_next;
    ptc_pkg::loc_t      loc_calc;
    logic               o_load;

    assign o_load  = !(o_valid_reg && down_hold);
    assign e_load  = !(e_valid_reg && !o_load);
    assign up_hold = !e_load;

    assign bc_next = e_load ? ptc_pkg::edge_class(in_data.bc_o, in_data.bc_q, in_data.qb,
                                                  in_data.qc, area_tol, coord_tol) : bc_reg;
    assign ca_next = e_load ? ptc_pkg::edge_class(in_data.ca_o, in_data.ca_q, in_data.qc,
                                                  in_data.qa, area_tol, coord_tol) : ca_reg;
    assign ab_next = e_load ? ptc_pkg::edge_class(in_data.ab_o, in_data.ab_q, in_data.qa,
                                                  in_data.qb, area_tol, coord_tol) : ab_reg;

    // first edge with a zero side test decides when no side disagrees
    always_comb
    begin
        if (!bc_reg.zero && !ca_reg.zero && !ab_reg.zero
            && !bc_reg.opp && !ca_reg.opp && !ab_reg.opp)
            loc_calc = ptc_pkg::LOC_INSIDE;
        else if ((!bc_reg.zero && bc_reg.opp) || (!ca_reg.zero && ca_reg.opp)
                 || (!ab_reg.zero && ab_reg.opp))
            loc_calc = ptc_pkg::LOC_OUTSIDE;
        else if (bc_reg.zero)
            loc_calc = bc_reg.seg ? ptc_pkg::LOC_EDGE : ptc_pkg::LOC_OUTSIDE;
        else if (ca_reg.zero)
            loc_calc = ca_reg.seg ? ptc_pkg::LOC_EDGE : ptc_pkg::LOC_OUTSIDE;
        else
            loc_calc = ab_reg.seg ? ptc_pkg::LOC_EDGE : ptc_pkg::LOC_OUTSIDE;
    end

    assign e_valid_next = e_load ? in_valid : e_valid_reg;
    assign o_valid_next = o_load ? e_valid_reg : o_valid_reg;
    assign loc_next     = o_load ? loc_calc : loc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bc_reg  <= bc_next;
        ca_reg  <= ca_next;
        ab_reg  <= ab_next;
        loc_reg <= loc_next;
    end

    assign out_valid = o_valid_reg;
    assign loc       = loc_reg;

endmodule

`default_nettype wire

@@ src/point_in_triangle_classifier_top.sv @@
// point_in_triangle_classifier_top: five-stage point-in-triangle classifier
// with an APB-style tolerance register port. Depends on ptc_pkg, ptc_regs,
// ptc_diff, ptc_cross and ptc_classify.
//
//   channel   handshake                      payload
//   query     query_valid / query_stall      query_x/y, vertex_a/b/c_x/y
//   result    result_valid / result_stall    location
//   config    psel penable pwrite pready     paddr, pwdata, prdata
//
// one beat in per cycle while query_stall is low, one result beat per query
// beat; an accepted query passes the differences, products, cross products,
// tolerance compares and decision register in that order
// each stage holds only while it is full and the stage after it holds, so
// bubbles fill up and query_stall rises only when all five stages are full
// reset clears the valid bits and both tolerances to zero
`default_nettype none

module point_in_triangle_classifier_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           query_valid,
    output logic                                query_stall,
    input  wire ptc_pkg::coord_t                query_x,
    input  wire ptc_pkg::coord_t                query_y,
    input  wire ptc_pkg::coord_t                vertex_a_x,
    input  wire ptc_pkg::coord_t                vertex_a_y,
    input  wire ptc_pkg::coord_t                vertex_b_x,
    input  wire ptc_pkg::coord_t                vertex_b_y,
    input  wire ptc_pkg::coord_t                vertex_c_x,
    input  wire ptc_pkg::coord_t                vertex_c_y,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [1:0]                     location,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ptc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ptc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    ptc_pkg::area_tol_t  area_tol;
    ptc_pkg::coord_tol_t coord_tol;
    logic                d_valid;
    logic                d_hold;
    ptc_pkg::diff_set_t  d_data;
    logic                x_valid;
    logic                x_hold;
    ptc_pkg::cross_set_t x_data;
    ptc_pkg::loc_t       loc;

    ptc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .area_tol  (area_tol),
        .coord_tol (coord_tol)
    );

    ptc_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query_valid),
        .up_hold   (query_stall),
        .qx        (query_x),
        .qy        (query_y),
        .ax        (vertex_a_x),
        .ay        (vertex_a_y),
        .bx        (vertex_b_x),
        .by        (vertex_b_y),
        .cx        (vertex_c_x),
        .cy        (vertex_c_y),
        .out_valid (d_valid),
        .down_hold (d_hold),
        .out_data  (d_data)
    );

    ptc_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .up_hold   (d_hold),
        .in_data   (d_data),
        .out_valid (x_valid),
        .down_hold (x_hold),
        .out_data  (x_data)
    );

    ptc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .up_hold   (x_hold),
        .in_data   (x_data),
        .area_tol  (area_tol),
        .coord_tol (coord_tol),
        .out_valid (result_valid),
        .down_hold (result_stall),
        .loc       (loc)
    );

    assign location = loc;

endmodule

`default_nettype wire

@@ src/ptc_checker.sv @@
// ptc_checker: port-level assertions for the classifier and the bind that
// attaches them to point_in_triangle_classifier_top. Depends on the top level.
`default_nettype none

module ptc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       query_valid,
    input wire logic       query_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [1:0] location
);

    // a stalled result beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(location))
    else $error("stalled result beat changed");

    // backpressure reaches the query side only through a full, stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> result_valid && result_stall)
    else $error("query stalled while output free");

    // an accepted query yields a valid result beat when the output side stays free
    assert property (@(posedge clk) disable iff (!rst_n)
        (query_valid && !query_stall && !result_stall) ##1 !result_stall ##1 !result_stall
        ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("result beat missing after five cycles");

    // unused location code never shows up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> location != 2'd3)
    else $error("invalid location code");

endmodule

bind point_in_triangle_classifier_top ptc_checker u_ptc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .location     (location)
);

`default_nettype wire

@@ test/tb_point_in_triangle_classifier_top.sv @@
// tb_point_in_triangle_classifier_top: self-checking bench for the point-in-triangle
// classifier; predicts each location from the tolerances and checks result beats in order.
// Depends on ptc_pkg and point_in_triangle_classifier_top.
`timescale 1ns / 100ps

module tb_point_in_triangle_classifier_top;

    localparam int LIMIT            = 400000;
    localparam int PIPE_DRAIN       = 12;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS      = 125;
    localparam logic [63:0] AREA_MASK  = 64'h0000_0003_FFFF_FFFF;
    localparam logic [63:0] COORD_MASK = 64'h0000_0000_0000_FFFF;
    localparam logic [ptc_pkg::APB_ADDR_W-1:0] ADDR_AREA_TOL  = {ptc_pkg::REG_AREA_TOL, 3'b000};
    localparam logic [ptc_pkg::APB_ADDR_W-1:0] ADDR_COORD_TOL = {ptc_pkg::REG_COORD_TOL, 3'b000};

    typedef struct {
        ptc_pkg::coord_t qx;
        ptc_pkg::coord_t qy;
        ptc_pkg::coord_t ax;
        ptc_pkg::coord_t ay;
        ptc_pkg::coord_t bx;
        ptc_pkg::coord_t by;
        ptc_pkg::coord_t cx;
        ptc_pkg::coord_t cy;
    } query_t;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    class location_scoreboard;
        longint        area_tol;
        longint        coord_tol;
        ptc_pkg::loc_t expected_locations[$];
        int            mismatches;

        function new();
            area_tol   = 0;
            coord_tol  = 0;
            mismatches = 0;
        endfunction

        function longint side_of(point_t p, point_t q, point_t t);
            return (p.x - q.x) * (t.y - p.y) - (t.x - p.x) * (p.y - q.y);
        endfunction

        function int area_sign(longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            if (mag <= area_tol)
                return 0;
            return (v < 0) ? -1 : 1;
        endfunction

        function int coord_sign(longint d);
            longint mag;
            mag = (d < 0) ? -d : d;
            if (mag <= coord_tol)
                return 0;
            return (d < 0) ? -1 : 1;
        endfunction

        function int edge_side(point_t t, point_t opp, point_t p, point_t q);
            int so;
            int st;
            so = area_sign(side_of(p, q, opp));
            st = area_sign(side_of(p, q, t));
            if (so == 0 || st == 0)
                return 0;
            return (so == st) ? 1 : -1;
        endfunction

        function bit on_segment(point_t t, point_t p, point_t q);
            int sx1;
            int sx2;
            int sy1;
            int sy2;
            if (area_sign(side_of(p, q, t)) != 0)
                return 1'b0;
            sx1 = coord_sign(t.x - p.x);
            sx2 = coord_sign(t.x - q.x);
            sy1 = coord_sign(t.y - p.y);
            sy2 = coord_sign(t.y - q.y);
            if (sx1 != 0 && sx2 != 0)
                return sx1 * sx2 == -1;
            if (sy1 != 0 && sy2 != 0)
                return sy1 * sy2 == -1;
            return 1'b0;
        endfunction

        function ptc_pkg::loc_t classify(query_t item);
            point_t q;
            point_t a;
            point_t b;
            point_t c;
            int     s_bc;
            int     s_ca;
            int     s_ab;
            bit     hit;
            q.x = item.qx;
            q.y = item.qy;
            a.x = item.ax;
            a.y = item.ay;
            b.x = item.bx;
            b.y = item.by;
            c.x = item.cx;
            c.y = item.cy;
            s_bc = edge_side(q, a, b, c);
            s_ca = edge_side(q, b, c, a);
            s_ab = edge_side(q, c, a, b);
            if (s_bc == 1 && s_ca == 1 && s_ab == 1)
                return ptc_pkg::LOC_INSIDE;
            if (s_bc == -1 || s_ca == -1 || s_ab == -1)
                return ptc_pkg::LOC_OUTSIDE;
            // only the first edge with a zero side test is examined
            if (s_bc == 0)
                hit = on_segment(q, b, c);
            else if (s_ca == 0)
                hit = on_segment(q, c, a);
            else
                hit = on_segment(q, a, b);
            return hit ? ptc_pkg::LOC_EDGE : ptc_pkg::LOC_OUTSIDE;
        endfunction

        function void note_query(query_t item);
            expected_locations.push_back(classify(item));
        endfunction

        function void check_location(logic [1:0] got);
            ptc_pkg::loc_t want;
            if (expected_locations.size() == 0)
            begin
                $error("location: expected none, got %0d", got);
                mismatches++;
                return;
            end
            want = expected_locations.pop_front();
            if (got !== want)
            begin
                $error("location: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_locations.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               query_valid;
    logic                               query_stall;
    ptc_pkg::coord_t                    query_x;
    ptc_pkg::coord_t                    query_y;
    ptc_pkg::coord_t                    vertex_a_x;
    ptc_pkg::coord_t                    vertex_a_y;
    ptc_pkg::coord_t                    vertex_b_x;
    ptc_pkg::coord_t                    vertex_b_y;
    ptc_pkg::coord_t                    vertex_c_x;
    ptc_pkg::coord_t                    vertex_c_y;
    logic                               result_valid;
    logic                               result_stall;
    logic [1:0]                         location;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [ptc_pkg::APB_ADDR_W-1:0]     paddr;
    logic [ptc_pkg::APB_DATA_W-1:0]     pwdata;
    logic [ptc_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    location_scoreboard scoreboard = new();
    bit                 sender_gaps;
    bit                 sink_stalls;
    bit                 long_hold_req;
    int                 cycle_count;

    point_in_triangle_classifier_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query_x      (query_x),
        .query_y      (query_y),
        .vertex_a_x   (vertex_a_x),
        .vertex_a_y   (vertex_a_y),
        .vertex_b_x   (vertex_b_x),
        .vertex_b_y   (vertex_b_y),
        .vertex_c_x   (vertex_c_x),
        .vertex_c_y   (vertex_c_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .location     (location),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL point_in_triangle_classifier_top");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic ptc_pkg::coord_t corner_coord();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return ptc_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic query_t make_query(input int qx, input int qy, input int ax, input int ay,
                                          input int bx, input int by, input int cx, input int cy);
        query_t item;
        item.qx = ptc_pkg::coord_t'(qx);
        item.qy = ptc_pkg::coord_t'(qy);
        item.ax = ptc_pkg::coord_t'(ax);
        item.ay = ptc_pkg::coord_t'(ay);
        item.bx = ptc_pkg::coord_t'(bx);
        item.by = ptc_pkg::coord_t'(by);
        item.cx = ptc_pkg::coord_t'(cx);
        item.cy = ptc_pkg::coord_t'(cy);
        return item;
    endfunction

    // mostly triangles built around one edge with the query on, near or off that edge
    function automatic query_t random_query();
        query_t item;
        int     pick;
        int     span;
        int     dx;
        int     dy;
        int     k;
        int     j;
        int     px;
        int     py;
        int     rot;
        int     first;
        int     flip;
        int     vx[3];
        int     vy[3];
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return make_query($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
        if (pick < 22)
        begin
            item.qx = corner_coord();
            item.qy = corner_coord();
            item.ax = corner_coord();
            item.ay = corner_coord();
            item.bx = corner_coord();
            item.by = corner_coord();
            item.cx = corner_coord();
            item.cy = corner_coord();
            return item;
        end
        span = ($urandom_range(0, 3) == 0) ? 2000 : 64;
        vx[0] = spread(12000);
        vy[0] = spread(12000);
        dx = spread(span);
        dy = spread(span);
        if (pick < 32)
            dx = 0;
        else if (pick < 40)
            dy = 0;
        k = $urandom_range(1, 8);
        vx[1] = vx[0] + k * dx;
        vy[1] = vy[0] + k * dy;
        if (pick < 50)
        begin
            j = int'($urandom_range(0, 12)) - 2;
            vx[2] = vx[0] + j * dx;
            vy[2] = vy[0] + j * dy;
        end
        else
        begin
            vx[2] = vx[0] + spread(8 * span);
            vy[2] = vy[0] + spread(8 * span);
        end
        j = int'($urandom_range(0, k + 4)) - 2;
        px = vx[0] + j * dx;
        py = vy[0] + j * dy;
        if (pick >= 82)
        begin
            px = vx[0] + spread(4 * span);
            py = vy[0] + spread(4 * span);
        end
        else if (pick >= 66)
        begin
            px = px + spread(3);
            py = py + spread(3);
        end
        rot = $urandom_range(0, 5);
        first = rot % 3;
        flip = rot / 3;
        return make_query(px, py, vx[first], vy[first],
                          vx[(first + 1 + flip) % 3], vy[(first + 1 + flip) % 3],
                          vx[(first + 2 - flip) % 3], vy[(first + 2 - flip) % 3]);
    endfunction

    task automatic apb_write(input logic [ptc_pkg::APB_ADDR_W-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ptc_pkg::APB_ADDR_W-1:0] addr, output logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_tolerances(input logic [63:0] area_word, input logic [63:0] coord_word);
        logic [63:0] readback;
        query_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        apb_write(ADDR_AREA_TOL, area_word);
        apb_write(ADDR_COORD_TOL, coord_word);
        scoreboard.area_tol  = longint'(area_word & AREA_MASK);
        scoreboard.coord_tol = longint'(coord_word & COORD_MASK);
        apb_read(ADDR_AREA_TOL, readback);
        if (readback !== (area_word & AREA_MASK))
        begin
            $error("area_tolerance: expected %0h, got %0h", area_word & AREA_MASK, readback);
            scoreboard.mismatches++;
        end
        apb_read(ADDR_COORD_TOL, readback);
        if (readback !== (coord_word & COORD_MASK))
        begin
            $error("coord_tolerance: expected %0h, got %0h", coord_word & COORD_MASK, readback);
            scoreboard.mismatches++;
        end
    endtask

    task automatic send_query(input query_t item);
        query_valid <= 1'b1;
        query_x     <= item.qx;
        query_y     <= item.qy;
        vertex_a_x  <= item.ax;
        vertex_a_y  <= item.ay;
        vertex_b_x  <= item.bx;
        vertex_b_y  <= item.by;
        vertex_c_x  <= item.cx;
        vertex_c_y  <= item.cy;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        scoreboard.note_query(item);
        if (sender_gaps && $urandom_range(0, 99) < 30)
        begin
            query_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                scoreboard.check_location(location);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        query_t directed_set[$];
        int     phase;
        int     n;
        rst_n       = 1'b0;
        query_valid = 1'b0;
        query_x     = '0;
        query_y     = '0;
        vertex_a_x  = '0;
        vertex_a_y  = '0;
        vertex_b_x  = '0;
        vertex_b_y  = '0;
        vertex_c_x  = '0;
        vertex_c_y  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        long_hold_req = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // exact tests at reset tolerances
        directed_set.push_back(make_query(256, 256, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(2048, 2048, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(512, 0, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(0, 512, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(512, 512, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(0, 0, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(256, 256, 0, 0, 0, 1024, 1024, 0));
        directed_set.push_back(make_query(768, 0, 0, 0, 512, 0, 1024, 0));
        directed_set.push_back(make_query(256, 0, 0, 0, 512, 0, 1024, 0));
        directed_set.push_back(make_query(2048, 0, 0, 0, 512, 0, 1024, 0));
        directed_set.push_back(make_query(256, 256, 0, 0, 512, 512, 512, 512));
        directed_set.push_back(make_query(0, 768, 0, 0, 0, 512, 0, 1024));
        directed_set.push_back(make_query(0, 2048, 0, 0, 0, 512, 0, 1024));
        directed_set.push_back(make_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
        directed_set.push_back(make_query(-32768, 0, -32768, -32768, 32767, -32768, -32768, 32767));
        directed_set.push_back(make_query(32767, 32767, -32768, -32768, 32767, -32768,
                                          -32768, 32767));
        directed_set.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed_set[i])
            send_query(directed_set[i]);
        directed_set.delete();

        // near misses around an edge, some of which the tolerances pull onto it
        write_tolerances(64'd2048, 64'd4);
        directed_set.push_back(make_query(512, 1, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(512, -1, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(1026, 0, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(2, 0, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(3, 512, 0, 0, 1024, 0, 0, 1024));
        directed_set.push_back(make_query(-3000, 5, 0, 0, 1024, 0, 0, 1024));
        foreach (directed_set[i])
            send_query(directed_set[i]);

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_tolerances(64'd0, 64'd0);
                1: write_tolerances('1, '1);
                2: write_tolerances(64'($urandom_range(0, 4096)), 64'($urandom_range(0, 16)));
                3: write_tolerances({$urandom, $urandom}, {$urandom, $urandom});
                4: write_tolerances(64'($urandom_range(0, 1 << 20)), 64'd0);
                default: write_tolerances(64'd0, 64'($urandom_range(0, 64)));
            endcase
            sender_gaps = (phase != 1) && (phase != 2);
            sink_stalls = (phase != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 20)
                    long_hold_req = 1'b1;
                if (phase == 3 && n == 60)
                begin
                    query_valid <= 1'b0;
                    @(posedge clk);
                    while (scoreboard.pending() != 0)
                        @(posedge clk);
                end
                send_query(random_query());
            end
        end

        query_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (scoreboard.mismatches == 0)
            $display("PASS point_in_triangle_classifier_top");
        else
            $display("FAIL point_in_triangle_classifier_top");
        $finish;
    end

endmodule
